/* rtl/core/scfp_pkg.sv */
`timescale 1ns / 1ps

package scfp_pkg;

  localparam int unsigned MAX_ID_LEN_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned TLEN_W = 5;
  localparam logic [TLEN_W-1:0] TLEN_MAX = 5'd31;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_CHARS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_LENGTH = 1'b1;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SEP = 8'h7c;
  localparam logic [7:0] CH_O = 8'h4f;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_1 = 8'h31;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_NO_HEADER = 4'd1;
  localparam logic [3:0] ST_BAD_HEADER = 4'd2;
  localparam logic [3:0] ST_NO_VERSION = 4'd3;
  localparam logic [3:0] ST_BAD_VERSION = 4'd4;
  localparam logic [3:0] ST_NO_ID = 4'd5;
  localparam logic [3:0] ST_ID_TOO_LONG = 4'd6;
  localparam logic [3:0] ST_NO_COMMAND = 4'd7;
  localparam logic [3:0] ST_NO_PARAM = 4'd8;
  localparam logic [3:0] ST_UNKNOWN_CMD = 4'd9;
  localparam logic [3:0] ST_BAD_PARAM = 4'd10;
  localparam logic [3:0] ST_ID_MISMATCH = 4'd11;

  localparam logic [2:0] CMD_UNKNOWN = 3'd0;
  localparam logic [2:0] CMD_PAIR = 3'd1;
  localparam logic [2:0] CMD_UNPAIR = 3'd2;
  localparam logic [2:0] CMD_SWITCH_ON = 3'd3;
  localparam logic [2:0] CMD_SWITCH_OFF = 3'd4;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_SEP = 2'd1;
  localparam logic [1:0] KIND_SKIP = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [2:0] command_code;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_byte;
    logic       last_byte;
  } q_item_t;

  typedef struct packed {
    logic [31:0] chars;
    logic [2:0]  length;
  } ver_cfg_t;

endpackage

/* rtl/core/switch_command_frame_parser.sv */
`timescale 1ns / 1ps

// Parses switch command texts that arrive one byte per transaction, with the final byte of each
// text marked by last_byte, and returns one registered result (status and command code) per
// text. One byte is accepted every cycle as long as the result side keeps up; a byte marked
// last waits only while a previous result is still stalled at the output. Accepted bytes pass
// through a small queue into the parser, and a result is registered once its last byte is popped.
// The parser takes one byte per cycle unless a last byte waits on a stalled result; the ID memory
// has one write and one read port. The user must write the expected version token and its length
// through the configuration port only while the block is idle; the block does not enforce this.
module switch_command_frame_parser #(
  parameter int unsigned MAX_ID_LEN = scfp_pkg::MAX_ID_LEN_DEF,
  parameter int unsigned QUEUE_DEPTH = scfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  scfp_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output scfp_pkg::out_item_t                 out_data,
  input  logic                               cfg_wr_en,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scfp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  scfp_pkg::ver_cfg_t ver_r, ver_nxt;
  logic q_full, push, pop, q_valid;
  scfp_pkg::q_item_t push_item, pop_item;

  always_comb begin
    ver_nxt = ver_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        scfp_pkg::CFG_VERSION_CHARS: ver_nxt.chars = cfg_wdata;
        scfp_pkg::CFG_VERSION_LENGTH: ver_nxt.length = cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r.chars <= '0;
      ver_r.length <= 3'd1;
    end else begin
      ver_r <= ver_nxt;
    end
  end

  assign in_stall = q_full;

  scfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  scfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  scfp_back #(
    .MAX_ID_LEN(MAX_ID_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ver_cfg   (ver_r),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop && pop_item.last_byte))
    else $error("result without a last byte");

  a_code_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == scfp_pkg::ST_OK ||
                   out_data.command_code == scfp_pkg::CMD_UNKNOWN))
    else $error("command code set on a failed text");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

/* rtl/core/scfp_ram.sv */
`timescale 1ns / 1ps

module scfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/scfp_front.sv */
`timescale 1ns / 1ps

module scfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  scfp_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output scfp_pkg::q_item_t  push_item
);

  logic ended_r;
  logic ended_nxt;
  logic is_nul;

  assign is_nul = (in_data.text_byte == scfp_pkg::CH_NUL);
  assign push = in_valid && !q_full;

  always_comb begin
    push_item.text_byte = in_data.text_byte;
    push_item.last_byte = in_data.last_byte;
    if (ended_r) begin
      push_item.kind = scfp_pkg::KIND_SKIP;
    end else if (is_nul || in_data.text_byte == scfp_pkg::CH_SEP) begin
      push_item.kind = scfp_pkg::KIND_SEP;
    end else begin
      push_item.kind = scfp_pkg::KIND_CHAR;
    end
  end

  always_comb begin
    ended_nxt = ended_r;
    if (push) begin
      ended_nxt = in_data.last_byte ? 1'b0 : (ended_r || is_nul);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r <= 1'b0;
    end else begin
      ended_r <= ended_nxt;
    end
  end

endmodule

/* rtl/core/scfp_queue.sv */
`timescale 1ns / 1ps

module scfp_queue #(
  parameter int unsigned DEPTH = scfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  scfp_pkg::q_item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output scfp_pkg::q_item_t  pop_item
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  scfp_pkg::q_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/core/scfp_back.sv */
`timescale 1ns / 1ps

module scfp_back #(
  parameter int unsigned MAX_ID_LEN = scfp_pkg::MAX_ID_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scfp_pkg::ver_cfg_t  ver_cfg,
  input  logic               q_valid,
  input  scfp_pkg::q_item_t   q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output scfp_pkg::out_item_t out_data
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_VERSION = 3'd1;
  localparam logic [2:0] PH_ID = 3'd2;
  localparam logic [2:0] PH_COMMAND = 3'd3;
  localparam logic [2:0] PH_PARAM = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam int unsigned AW = $clog2(2 * MAX_ID_LEN);
  localparam logic [scfp_pkg::TLEN_W-1:0] POS_LIMIT = scfp_pkg::TLEN_W'(MAX_ID_LEN);

  typedef struct packed {
    logic [2:0]                   phase;
    logic [scfp_pkg::TLEN_W-1:0]  tlen;
    logic                         insep;
    logic [3:0]                   err;
    logic                         tmatch;
    logic                         eq;
    logic [7:0]                   cmd;
    logic [7:0]                   par;
    logic [1:0]                   flags;
    logic [scfp_pkg::TLEN_W-1:0]  rxlen;
  } pst_t;

  localparam pst_t PST_CLEAR = '{
    phase: PH_HEADER, tlen: '0, insep: 1'b1, err: scfp_pkg::ST_OK, tmatch: 1'b1,
    eq: 1'b1, cmd: '0, par: '0, flags: '0, rxlen: '0
  };

  function automatic pst_t finish_tok(input pst_t s, input logic [2:0] vlen,
                                      input logic [scfp_pkg::TLEN_W-1:0] slen);
    pst_t r;
    r = s;
    if (!s.insep) begin
      r.insep = 1'b1;
      case (s.phase)
        PH_HEADER: begin
          if (!(s.tmatch && s.tlen == 5'd2)) r.err = scfp_pkg::ST_BAD_HEADER;
        end
        PH_VERSION: begin
          if (!(s.tmatch && s.tlen == {2'b00, vlen})) r.err = scfp_pkg::ST_BAD_VERSION;
        end
        PH_ID: begin
          r.rxlen = s.tlen;
          if (s.tlen != slen) r.eq = 1'b0;
        end
        PH_COMMAND: begin
          if (s.tlen == 5'd1) r.flags[0] = 1'b1;
        end
        PH_PARAM: begin
          if (s.tlen == 5'd1) r.flags[1] = 1'b1;
        end
        default: ;
      endcase
      if (s.phase < PH_DONE) r.phase = s.phase + 3'd1;
    end
    return r;
  endfunction

  pst_t st_r, st_nxt;
  logic sel_r, sel_nxt;
  logic [scfp_pkg::TLEN_W-1:0] slen_r, slen_nxt;
  logic pend_r, pend_nxt;
  logic [7:0] pend_byte_r;
  logic out_valid_r, out_valid_nxt;
  scfp_pkg::out_item_t out_data_r, out_data_nxt;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0] ram_rd_data;

  logic [scfp_pkg::TLEN_W-1:0] pos;
  logic [7:0] b;
  logic id_full, p1, p0;
  pst_t s;

  assign b = q_item.text_byte;
  assign pop = q_valid && !(q_item.last_byte && out_valid_r && out_stall);

  always_comb begin
    s = st_r;
    s.eq = st_r.eq && !(pend_r && ram_rd_data != pend_byte_r);
    sel_nxt = sel_r;
    slen_nxt = slen_r;
    pend_nxt = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    pos = s.insep ? '0 : s.tlen;
    id_full = 1'b0;
    p1 = 1'b0;
    p0 = 1'b0;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (pop) begin
      if (q_item.kind != scfp_pkg::KIND_SKIP && s.err == scfp_pkg::ST_OK) begin
        if (q_item.kind == scfp_pkg::KIND_SEP) begin
          s = finish_tok(s, ver_cfg.length, slen_r);
        end else begin
          if (s.insep) begin
            s.insep = 1'b0;
            s.tmatch = 1'b1;
            s.tlen = '0;
            if (s.phase == PH_ID) s.eq = 1'b1;
          end
          case (s.phase)
            PH_HEADER: begin
              if (pos >= 5'd2 || b != ((pos == '0) ? scfp_pkg::CH_O : scfp_pkg::CH_T)) begin
                s.tmatch = 1'b0;
              end
            end
            PH_VERSION: begin
              if (pos >= 5'd4 || b != ver_cfg.chars[{pos[1:0], 3'b000} +: 8]) begin
                s.tmatch = 1'b0;
              end
            end
            PH_ID: begin
              if (pos >= POS_LIMIT) begin
                s.err = scfp_pkg::ST_ID_TOO_LONG;
                id_full = 1'b1;
              end else begin
                ram_we = 1'b1;
                if (pos >= slen_r) begin
                  s.eq = 1'b0;
                end else begin
                  ram_re = 1'b1;
                  pend_nxt = 1'b1;
                end
              end
            end
            PH_COMMAND: begin
              if (pos == '0) s.cmd = b;
            end
            PH_PARAM: begin
              if (pos == '0) s.par = b;
            end
            default: ;
          endcase
          if (!id_full && s.tlen != scfp_pkg::TLEN_MAX) s.tlen = s.tlen + 5'd1;
        end
      end
      if (q_item.last_byte) begin
        if (s.err == scfp_pkg::ST_OK) s = finish_tok(s, ver_cfg.length, slen_r);
        p1 = s.flags[1] && s.par == scfp_pkg::CH_1;
        p0 = s.flags[1] && s.par == scfp_pkg::CH_0;
        out_data_nxt.command_code = scfp_pkg::CMD_UNKNOWN;
        if (s.err != scfp_pkg::ST_OK) begin
          out_data_nxt.status = s.err;
        end else if (s.phase != PH_DONE) begin
          case (s.phase)
            PH_HEADER: out_data_nxt.status = scfp_pkg::ST_NO_HEADER;
            PH_VERSION: out_data_nxt.status = scfp_pkg::ST_NO_VERSION;
            PH_ID: out_data_nxt.status = scfp_pkg::ST_NO_ID;
            PH_COMMAND: out_data_nxt.status = scfp_pkg::ST_NO_COMMAND;
            default: out_data_nxt.status = scfp_pkg::ST_NO_PARAM;
          endcase
        end else if (!s.flags[0] || (s.cmd != scfp_pkg::CH_P && s.cmd != scfp_pkg::CH_S)) begin
          out_data_nxt.status = scfp_pkg::ST_UNKNOWN_CMD;
        end else if (!p1 && !p0) begin
          out_data_nxt.status = scfp_pkg::ST_BAD_PARAM;
        end else if (s.cmd == scfp_pkg::CH_P) begin
          out_data_nxt.status = scfp_pkg::ST_OK;
          if (p1) begin
            sel_nxt = !sel_r;
            slen_nxt = s.rxlen;
            out_data_nxt.command_code = scfp_pkg::CMD_PAIR;
          end else begin
            slen_nxt = '0;
            out_data_nxt.command_code = scfp_pkg::CMD_UNPAIR;
          end
        end else if (!s.eq) begin
          out_data_nxt.status = scfp_pkg::ST_ID_MISMATCH;
        end else begin
          out_data_nxt.status = scfp_pkg::ST_OK;
          out_data_nxt.command_code = p1 ? scfp_pkg::CMD_SWITCH_ON : scfp_pkg::CMD_SWITCH_OFF;
        end
        out_valid_nxt = 1'b1;
        s = PST_CLEAR;
        pend_nxt = 1'b0;
      end
    end
    st_nxt = s;
  end

  // The new ID goes to the bank that is not selected; the stored ID is read from the selected one.
  assign ram_wr_addr = sel_r ? AW'(pos) : AW'(MAX_ID_LEN) + AW'(pos);
  assign ram_rd_addr = sel_r ? AW'(MAX_ID_LEN) + AW'(pos) : AW'(pos);

  scfp_ram #(
    .WIDTH(8),
    .DEPTH(2 * MAX_ID_LEN)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (b),
    .rd_en   (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PST_CLEAR;
      sel_r <= 1'b0;
      slen_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      sel_r <= sel_nxt;
      slen_r <= slen_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= b;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
